// File: hdl/rte_pkg.sv
package rte_pkg;

  // Default sizes of the timer arithmetic.
  localparam int TIME_BITS_DEF  = 48;
  localparam int COUNT_BITS_DEF = 33;

  // Fixed widths of the ports and registers.
  localparam int RC_W   = 33;
  localparam int FE_W   = 48;
  localparam int PER_W  = 47;
  localparam int NOW_W  = 48;
  localparam int EXP_W  = 48;
  localparam int FUNC_W = 3;
  localparam int CODE_W = 3;
  localparam int DATA_W = 64;
  localparam int ADDR_W = 5;

  // Command codes.
  localparam logic [FUNC_W-1:0] FN_ARM     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_TRIGGER = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PAUSE   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RESUME  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_KILL    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REVISE  = 3'd5;

  // Event codes.
  localparam logic [CODE_W-1:0] EV_NONE     = 3'd0;
  localparam logic [CODE_W-1:0] EV_FIRED    = 3'd1;
  localparam logic [CODE_W-1:0] EV_FINISHED = 3'd2;
  localparam logic [CODE_W-1:0] EV_KILLED   = 3'd3;
  localparam logic [CODE_W-1:0] EV_PAUSED   = 3'd4;
  localparam logic [CODE_W-1:0] EV_RESUMED  = 3'd5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_REPEAT_COUNT = 2'd0;
  localparam logic [1:0] REG_FIRST_EXPIRY = 2'd1;
  localparam logic [1:0] REG_PERIOD       = 2'd2;

  // Register reset values.
  localparam logic [RC_W-1:0]  RC_RESET  = '1;
  localparam logic [FE_W-1:0]  FE_RESET  = '0;
  localparam logic [PER_W-1:0] PER_RESET = PER_W'(1000);

  // Control word of the bit-serial adder.
  typedef struct packed {
    logic start;
    logic inv_b;
    logic inv_c;
  } alu_cmd_t;

endpackage

// File: hdl/rte_serial_alu.sv
// Bit-serial three-operand adder: sum = a + b' + c', where b' and c' are
// optionally complemented (with a carry-in of one) to form subtractions.
// One bit per cycle, LSB first; the sum shifts into the a register.
module rte_serial_alu import rte_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  alu_cmd_t             cmd,
  input  logic [TIME_BITS-1:0] op_a,
  input  logic [TIME_BITS-1:0] op_b,
  input  logic [TIME_BITS-1:0] op_c,
  output logic                 done,
  output logic [TIME_BITS-1:0] sum
);

  localparam int CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);

  logic [TIME_BITS-1:0] a_sr_r, a_sr_nxt;
  logic [TIME_BITS-1:0] b_sr_r, b_sr_nxt;
  logic [TIME_BITS-1:0] c_sr_r, c_sr_nxt;
  logic                 c1_r, c1_nxt;
  logic                 c2_r, c2_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic                 s1, s2;

  // Two chained full adders on the current bit.
  always_comb begin
    s1 = a_sr_r[0] ^ b_sr_r[0] ^ c1_r;
    s2 = s1 ^ c_sr_r[0] ^ c2_r;
  end

  // Load on start, then shift one bit per cycle.
  always_comb begin
    a_sr_nxt = a_sr_r;
    b_sr_nxt = b_sr_r;
    c_sr_nxt = c_sr_r;
    c1_nxt   = c1_r;
    c2_nxt   = c2_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      a_sr_nxt = op_a;
      b_sr_nxt = op_b ^ {TIME_BITS{cmd.inv_b}};
      c_sr_nxt = op_c ^ {TIME_BITS{cmd.inv_c}};
      c1_nxt   = cmd.inv_b;
      c2_nxt   = cmd.inv_c;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      a_sr_nxt = {s2, a_sr_r[TIME_BITS-1:1]};
      b_sr_nxt = {1'b0, b_sr_r[TIME_BITS-1:1]};
      c_sr_nxt = {1'b0, c_sr_r[TIME_BITS-1:1]};
      c1_nxt   = (a_sr_r[0] & b_sr_r[0]) | (a_sr_r[0] & c1_r) | (b_sr_r[0] & c1_r);
      c2_nxt   = (s1 & c_sr_r[0]) | (s1 & c2_r) | (c_sr_r[0] & c2_r);
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_sr_r <= a_sr_nxt;
    b_sr_r <= b_sr_nxt;
    c_sr_r <= c_sr_nxt;
    c1_r   <= c1_nxt;
    c2_r   <= c2_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign sum  = a_sr_r;

endmodule

// File: hdl/rte_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// The remainder always stays below the divisor, so it fits in TIME_BITS.
module rte_mod_unit import rte_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TIME_BITS-1:0] divisor,
  output logic                 done,
  output logic [TIME_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(TIME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_BITS - 1);

  logic [TIME_BITS-1:0] q_sr_r, q_sr_nxt;
  logic [TIME_BITS-1:0] div_r, div_nxt;
  logic [TIME_BITS-1:0] r_r, r_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [TIME_BITS:0]   r_shift;
  logic [TIME_BITS:0]   r_diff;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    r_shift = {r_r, q_sr_r[TIME_BITS-1]};
    r_diff  = r_shift - {1'b0, div_r};
  end

  always_comb begin
    q_sr_nxt = q_sr_r;
    div_nxt  = div_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_sr_nxt = dividend;
      div_nxt  = divisor;
      r_nxt    = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      q_sr_nxt = {q_sr_r[TIME_BITS-2:0], 1'b0};
      // Keep the difference unless it borrowed.
      r_nxt    = r_diff[TIME_BITS] ? r_shift[TIME_BITS-1:0] : r_diff[TIME_BITS-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_LAST) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_sr_r <= q_sr_nxt;
    div_r  <= div_nxt;
    r_r    <= r_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

// File: hdl/repeating_timer_entry.sv
// Channel   | Ports                                           | Handshake
// ----------+-------------------------------------------------+---------------------------
// command   | start, busy, in_func, in_time_now               | taken when start && !busy
// result    | out_valid, out_event_code, out_last,            | one cycle per word, no stall
//           | out_is_active, out_is_paused, out_expiry_out    |
// registers | psel, penable, pwrite, paddr, pwdata, prdata,   | APB write in access phase
//           | pready                                          |
//
// Arm, pause, kill, unused codes and commands with no effect go from EXEC straight to EMIT1.
// A trigger on an active timer and a resume that applies make one pass through the
// bit-serial adder (ALU); a trigger that fires and finishes also passes through EMIT2.
// Revise with a nonzero period makes a serial lag pass; if REVCHK accepts the lag, it runs
// the remainder unit at one quotient bit per cycle, then a second pass for the new expiry.
// A trigger that fires and finishes delivers its two words on consecutive cycles.
// Reset is synchronous and active low; it loads the register defaults and clears the timer.
module repeating_timer_entry import rte_pkg::*; #(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic signed [NOW_W-1:0]  in_time_now,
  output logic                     out_valid,
  output logic [CODE_W-1:0]        out_event_code,
  output logic                     out_last,
  output logic                     out_is_active,
  output logic                     out_is_paused,
  output logic signed [EXP_W-1:0]  out_expiry_out
);

  localparam int WIDE_W = (TIME_BITS > PER_W) ? TIME_BITS : PER_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EXEC   = 8'b0000_0010,
    ST_LAG    = 8'b0000_0100,
    ST_REVCHK = 8'b0000_1000,
    ST_MOD    = 8'b0001_0000,
    ST_ALU    = 8'b0010_0000,
    ST_EMIT1  = 8'b0100_0000,
    ST_EMIT2  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [RC_W-1:0] rc_r, rc_nxt;
  logic signed [FE_W-1:0] fe_r, fe_nxt;
  logic [PER_W-1:0]       per_r, per_nxt;

  logic                  active_r, active_nxt;
  logic                  paused_r, paused_nxt;
  logic [COUNT_BITS-1:0] remaining_r, remaining_nxt;
  logic [TIME_BITS-1:0]  expiry_r, expiry_nxt;
  logic [TIME_BITS-1:0]  paused_at_r, paused_at_nxt;

  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [CODE_W-1:0]     code_a_r, code_a_nxt;
  logic [CODE_W-1:0]     code_b_r, code_b_nxt;
  logic                  two_r, two_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]        out_code_r, out_code_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_act_r, out_act_nxt;
  logic                     out_pau_r, out_pau_nxt;
  logic signed [EXP_W-1:0]  out_exp_r, out_exp_nxt;

  alu_cmd_t             alu_cmd;
  logic [TIME_BITS-1:0] alu_a, alu_b, alu_c;
  logic                 alu_done;
  logic [TIME_BITS-1:0] alu_sum;

  logic                 mod_start;
  logic                 mod_done;
  logic [TIME_BITS-1:0] mod_rem;
  logic [TIME_BITS-1:0] per_t;

  logic                  rem_nz, rem_pos;
  logic [COUNT_BITS-1:0] rem_dec, rem_after;
  logic                  rem_fin;
  logic                  lag_ok;
  logic                  accept;
  logic                  cfg_wr;

  assign accept = start && (state_r == ST_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign per_t  = TIME_BITS'(per_r);

  // Register file writes.
  always_comb begin
    rc_nxt  = rc_r;
    fe_nxt  = fe_r;
    per_nxt = per_r;
    if (cfg_wr) begin
      case (paddr[ADDR_W-1:3])
        REG_REPEAT_COUNT: rc_nxt  = pwdata[RC_W-1:0];
        REG_FIRST_EXPIRY: fe_nxt  = pwdata[FE_W-1:0];
        REG_PERIOD:       per_nxt = pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Register file reads.
  always_comb begin
    case (paddr[ADDR_W-1:3])
      REG_REPEAT_COUNT: prdata = DATA_W'(rc_r);
      REG_FIRST_EXPIRY: prdata = DATA_W'(fe_r);
      REG_PERIOD:       prdata = DATA_W'(per_r);
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Repeat count bookkeeping for a trigger.
  always_comb begin
    rem_nz    = |remaining_r;
    rem_pos   = !remaining_r[COUNT_BITS-1];
    rem_dec   = remaining_r - COUNT_BITS'(1);
    rem_after = (rem_nz && rem_pos) ? rem_dec : remaining_r;
    rem_fin   = (rem_after == '0);
  end

  // The lag must be a real lag (expiry behind now) and longer than one period.
  always_comb begin
    lag_ok = (|alu_sum) &&
             (!alu_sum[TIME_BITS-1] || !(|alu_sum[TIME_BITS-2:0])) &&
             (WIDE_W'(alu_sum) > WIDE_W'(per_r));
  end

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    paused_nxt    = paused_r;
    remaining_nxt = remaining_r;
    expiry_nxt    = expiry_r;
    paused_at_nxt = paused_at_r;
    func_nxt      = func_r;
    now_nxt       = now_r;
    code_a_nxt    = code_a_r;
    code_b_nxt    = code_b_r;
    two_nxt       = two_r;
    alu_cmd       = '0;
    alu_a         = '0;
    alu_b         = '0;
    alu_c         = '0;
    mod_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_func;
          now_nxt   = TIME_BITS'(in_time_now);
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        code_a_nxt = EV_NONE;
        code_b_nxt = EV_NONE;
        two_nxt    = 1'b0;
        state_nxt  = ST_EMIT1;
        case (func_r)
          FN_ARM: begin
            remaining_nxt = COUNT_BITS'(rc_r);
            expiry_nxt    = TIME_BITS'(fe_r);
            active_nxt    = 1'b1;
            paused_nxt    = 1'b0;
          end
          FN_TRIGGER: begin
            if (active_r) begin
              remaining_nxt = rem_after;
              if (rem_fin) begin
                active_nxt = 1'b0;
              end
              if (rem_nz) begin
                code_a_nxt = EV_FIRED;
                code_b_nxt = EV_FINISHED;
                two_nxt    = rem_fin;
              end else begin
                code_a_nxt = EV_FINISHED;
              end
              alu_cmd.start = 1'b1;
              alu_a         = expiry_r;
              alu_b         = per_t;
              state_nxt     = ST_ALU;
            end
          end
          FN_PAUSE: begin
            if (active_r && !paused_r) begin
              paused_nxt    = 1'b1;
              paused_at_nxt = now_r;
              code_a_nxt    = EV_PAUSED;
            end
          end
          FN_RESUME: begin
            if (active_r && paused_r) begin
              paused_nxt    = 1'b0;
              code_a_nxt    = EV_RESUMED;
              alu_cmd.start = 1'b1;
              alu_cmd.inv_c = 1'b1;
              alu_a         = now_r;
              alu_b         = expiry_r;
              alu_c         = paused_at_r;
              state_nxt     = ST_ALU;
            end
          end
          FN_KILL: begin
            if (active_r) begin
              active_nxt = 1'b0;
              code_a_nxt = EV_KILLED;
            end
          end
          FN_REVISE: begin
            // Lag = now - expiry, found serially first.
            if (|per_r) begin
              alu_cmd.start = 1'b1;
              alu_cmd.inv_b = 1'b1;
              alu_a         = now_r;
              alu_b         = expiry_r;
              state_nxt     = ST_LAG;
            end
          end
          default: ;
        endcase
      end

      ST_LAG: begin
        if (alu_done) begin
          state_nxt = ST_REVCHK;
        end
      end

      ST_REVCHK: begin
        if (lag_ok) begin
          mod_start = 1'b1;
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_EMIT1;
        end
      end

      ST_MOD: begin
        // Skipping whole periods lands the expiry at now minus (lag mod period).
        if (mod_done) begin
          alu_cmd.start = 1'b1;
          alu_cmd.inv_b = 1'b1;
          alu_a         = now_r;
          alu_b         = mod_rem;
          state_nxt     = ST_ALU;
        end
      end

      ST_ALU: begin
        if (alu_done) begin
          expiry_nxt = alu_sum;
          state_nxt  = ST_EMIT1;
        end
      end

      ST_EMIT1: begin
        state_nxt = two_r ? ST_EMIT2 : ST_IDLE;
      end

      ST_EMIT2: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result word register.
  always_comb begin
    out_valid_nxt = 1'b0;
    out_code_nxt  = out_code_r;
    out_last_nxt  = out_last_r;
    out_act_nxt   = out_act_r;
    out_pau_nxt   = out_pau_r;
    out_exp_nxt   = out_exp_r;
    if ((state_r == ST_EMIT1) || (state_r == ST_EMIT2)) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = (state_r == ST_EMIT2) ? code_b_r : code_a_r;
      out_last_nxt  = (state_r == ST_EMIT2) || !two_r;
      out_act_nxt   = active_r;
      out_pau_nxt   = paused_r;
      out_exp_nxt   = EXP_W'(signed'(expiry_r));
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    now_r      <= now_nxt;
    code_a_r   <= code_a_nxt;
    code_b_r   <= code_b_nxt;
    two_r      <= two_nxt;
    out_code_r <= out_code_nxt;
    out_last_r <= out_last_nxt;
    out_act_r  <= out_act_nxt;
    out_pau_r  <= out_pau_nxt;
    out_exp_r  <= out_exp_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rc_r        <= RC_RESET;
      fe_r        <= FE_RESET;
      per_r       <= PER_RESET;
      active_r    <= 1'b0;
      paused_r    <= 1'b0;
      remaining_r <= '0;
      expiry_r    <= '0;
      paused_at_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      fe_r        <= fe_nxt;
      per_r       <= per_nxt;
      active_r    <= active_nxt;
      paused_r    <= paused_nxt;
      remaining_r <= remaining_nxt;
      expiry_r    <= expiry_nxt;
      paused_at_r <= paused_at_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Bit-serial adder shared by trigger, resume and both revise passes.
  rte_serial_alu #(
    .TIME_BITS(TIME_BITS)
  ) u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (alu_cmd),
    .op_a (alu_a),
    .op_b (alu_b),
    .op_c (alu_c),
    .done (alu_done),
    .sum  (alu_sum)
  );

  // Remainder of the lag by the period.
  rte_mod_unit #(
    .TIME_BITS(TIME_BITS)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(alu_sum),
    .divisor (per_t),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;
  assign out_last       = out_last_r;
  assign out_is_active  = out_act_r;
  assign out_is_paused  = out_pau_r;
  assign out_expiry_out = out_exp_r;

endmodule

// File: hdl/rte_chk.sv
// Port-level checks on the timer entry.
module rte_chk import rte_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CODE_W-1:0] out_event_code,
  input logic              out_last,
  input logic              out_is_active,
  input logic              out_is_paused
);

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // The only two-word result is fired followed at once by finished.
  a_pair_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (out_event_code == EV_FIRED))
    else $error("non-final word is not a firing");

  a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=>
      (out_valid && out_last && (out_event_code == EV_FINISHED)))
    else $error("firing word not followed by finished word");

  // A finished or killed timer reports itself inactive.
  a_stop_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_event_code == EV_FINISHED) || (out_event_code == EV_KILLED)))
      |-> !out_is_active)
    else $error("stopped timer still reports active");

  // A pause word shows an active, paused timer.
  a_pause_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_code == EV_PAUSED)) |-> (out_is_active && out_is_paused))
    else $error("pause word with wrong flags");

endmodule

bind repeating_timer_entry rte_chk u_rte_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_event_code(out_event_code),
  .out_last      (out_last),
  .out_is_active (out_is_active),
  .out_is_paused (out_is_paused)
);
